// ===== rtl/sync_framed_command_parser_macros.svh =====
// Assertion macros used by the checker file.
`ifndef SYNC_FRAMED_COMMAND_PARSER_MACROS_SVH
`define SYNC_FRAMED_COMMAND_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SFCP_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("Assertion failed: implication does not hold.");

// Next-cycle implication, not disabled by reset.
`define SFCP_ASSERT_NEXT(label, clk, cond, prop) \
   label: assert property (@(posedge clk) (cond) |=> (prop)) \
      else $error("Assertion failed: next-cycle implication does not hold.");

`endif

// ===== rtl/sfcp_pkg.sv =====
package sfcp_pkg;

   localparam int ERROR_COUNT_BITS = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CSR_SYNC_FIRST  = 2'd0,
      CSR_SYNC_SECOND = 2'd1,
      CSR_CMD_TYPE    = 2'd2,
      CSR_DUMP_TYPE   = 2'd3
   } csr_index_type;

   localparam logic [7:0] SYNC_FIRST_RESET  = 8'd65;
   localparam logic [7:0] SYNC_SECOND_RESET = 8'd113;
   localparam logic [7:0] CMD_TYPE_RESET    = 8'd67;
   localparam logic [7:0] DUMP_TYPE_RESET   = 8'd70;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_GOOD  = 2'd1,
      KIND_ERROR = 2'd2
   } result_kind_type;

   typedef enum logic [3:0] {
      ST_SYNC1   = 4'd0,
      ST_SYNC2   = 4'd1,
      ST_TYPE    = 4'd2,
      ST_RQ1     = 4'd3,
      ST_RQ2     = 4'd4,
      ST_RQ3     = 4'd5,
      ST_RQ4     = 4'd6,
      ST_LEN     = 4'd7,
      ST_ROWS    = 4'd8,
      ST_FLOATS  = 4'd9,
      ST_PAYLOAD = 4'd10,
      ST_CHECK1  = 4'd11,
      ST_CHECK2  = 4'd12
   } parse_state_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  data_byte;
      logic [7:0]  byte_index;
      logic        frame_is_dump;
      logic [31:0] request_tag;
      logic [7:0]  frame_length;
      logic [15:0] error_total;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] index;
      logic [7:0] wdata;
   } csr_write_type;

endpackage

// ===== rtl/sync_framed_command_parser.sv =====
// Sync-framed command parser with a two-sum 8-bit checksum.
// Input channel: one received byte per transaction, taken when push is high
// and full is low. Result channel: the oldest result is on the rsp_ ports
// while empty is low and leaves on a cycle with pop high.
// A result is a stored payload byte with its buffer index, a frame-accepted
// report or a checksum-error report, along with the frame's kind, request id,
// end position and the running error count.
// Configuration: csr_valid with csr_index and csr_wdata writes one of the four
// match bytes (sync first, sync second, command type, dump type); csr_ready
// is always high and indexes above three are ignored. Write only while idle.
// Throughput is one byte per cycle while full is low. A byte that yields a
// result writes it into the queue as the byte is taken; it reaches the result
// ports once older results have left. The parser next state is combinational.
// A four-entry result queue separates the parser from the receiver. When the
// receiver stalls the queue fills and full rises, holding off input.
// Reset restores the default match bytes, clears the parser state, the error
// count and the queue; the parser then hunts for the first sync byte.
module sync_framed_command_parser
   import sfcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_byte_in,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [7:0]  rsp_byte_index,
   output logic        rsp_frame_is_dump,
   output logic [31:0] rsp_request_tag,
   output logic [7:0]  rsp_frame_length,
   output logic [15:0] rsp_error_total,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   logic          accept;
   logic          result_valid;
   result_type    result;
   result_type    head;
   csr_write_type csr_write;

   assign csr_ready       = 1'b1;
   assign accept          = push & ~full;
   assign csr_write.valid = csr_valid & csr_ready;
   assign csr_write.index = csr_index;
   assign csr_write.wdata = csr_wdata;

   sfcp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .byte_in      (req_byte_in),
      .csr_write    (csr_write),
      .result_valid (result_valid),
      .result       (result)
   );

   sfcp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (result_valid),
      .wr_data (result),
      .full    (full),
      .rd_en   (pop),
      .empty   (empty),
      .rd_data (head)
   );

   assign rsp_result_kind   = head.result_kind;
   assign rsp_data_byte     = head.data_byte;
   assign rsp_byte_index    = head.byte_index;
   assign rsp_frame_is_dump = head.frame_is_dump;
   assign rsp_request_tag   = head.request_tag;
   assign rsp_frame_length  = head.frame_length;
   assign rsp_error_total   = head.error_total;

endmodule

// ===== rtl/sfcp_front.sv =====
module sfcp_front
   import sfcp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    byte_in,
   input  csr_write_type csr_write,
   output logic          result_valid,
   output result_type    result
);

   logic [7:0]                  sync_first_ff, sync_first_in;
   logic [7:0]                  sync_second_ff, sync_second_in;
   logic [7:0]                  cmd_type_ff, cmd_type_in;
   logic [7:0]                  dump_type_ff, dump_type_in;

   parse_state_type             state_ff, state_in;
   logic [7:0]                  sum_a_ff, sum_a_in;
   logic [7:0]                  sum_b_ff, sum_b_in;
   logic [31:0]                 request_ff, request_in;
   logic [7:0]                  end_ff, end_in;
   logic [7:0]                  position_ff, position_in;
   logic [ERROR_COUNT_BITS-1:0] error_ff, error_in;
   logic                        dump_ff, dump_in;

   logic [7:0]                  sum_a_add;
   logic [7:0]                  sum_b_add;
   logic [7:0]                  position_inc;
   logic [5:0]                  dump_product;
   logic                        hit;
   result_kind_type             kind;
   logic [7:0]                  out_data;
   logic [7:0]                  out_index;

   always_comb begin
      sync_first_in  = sync_first_ff;
      sync_second_in = sync_second_ff;
      cmd_type_in    = cmd_type_ff;
      dump_type_in   = dump_type_ff;
      if (csr_write.valid) begin
         case (csr_write.index)
            8'(CSR_SYNC_FIRST):  sync_first_in  = csr_write.wdata;
            8'(CSR_SYNC_SECOND): sync_second_in = csr_write.wdata;
            8'(CSR_CMD_TYPE):    cmd_type_in    = csr_write.wdata;
            8'(CSR_DUMP_TYPE):   dump_type_in   = csr_write.wdata;
            default: ;
         endcase
      end
   end

   assign sum_a_add    = sum_a_ff + byte_in;
   assign sum_b_add    = sum_b_ff + sum_a_add;
   assign position_inc = position_ff + 8'd1;
   assign dump_product = 6'(end_ff[5:0] * byte_in[5:0]);

   always_comb begin
      state_in    = state_ff;
      sum_a_in    = sum_a_ff;
      sum_b_in    = sum_b_ff;
      request_in  = request_ff;
      end_in      = end_ff;
      position_in = position_ff;
      error_in    = error_ff;
      dump_in     = dump_ff;
      hit         = 1'b0;
      kind        = KIND_BYTE;
      out_data    = byte_in;
      out_index   = position_ff;
      case (state_ff)
         ST_SYNC1: begin
            if (byte_in == sync_first_ff) begin
               state_in = ST_SYNC2;
            end
         end
         ST_SYNC2: begin
            state_in = (byte_in == sync_second_ff) ? ST_TYPE : ST_SYNC1;
         end
         ST_TYPE: begin
            if (byte_in == cmd_type_ff) begin
               sum_a_in = 8'd0;
               sum_b_in = 8'd0;
               dump_in  = 1'b0;
               state_in = ST_RQ1;
            end else if (byte_in == dump_type_ff) begin
               sum_a_in    = 8'd0;
               sum_b_in    = 8'd0;
               dump_in     = 1'b1;
               position_in = 8'd1;
               state_in    = ST_ROWS;
            end else begin
               state_in = ST_SYNC1;
            end
         end
         ST_RQ1: begin
            sum_a_in         = sum_a_add;
            sum_b_in         = sum_b_add;
            request_in[7:0]  = byte_in;
            state_in         = ST_RQ2;
         end
         ST_RQ2: begin
            sum_a_in         = sum_a_add;
            sum_b_in         = sum_b_add;
            request_in[15:8] = byte_in;
            state_in         = ST_RQ3;
         end
         ST_RQ3: begin
            sum_a_in          = sum_a_add;
            sum_b_in          = sum_b_add;
            request_in[23:16] = byte_in;
            state_in          = ST_RQ4;
         end
         ST_RQ4: begin
            sum_a_in          = sum_a_add;
            sum_b_in          = sum_b_add;
            request_in[31:24] = byte_in;
            state_in          = ST_LEN;
         end
         ST_LEN: begin
            sum_a_in    = sum_a_add;
            sum_b_in    = sum_b_add;
            end_in      = byte_in;
            position_in = 8'd0;
            state_in    = ST_PAYLOAD;
         end
         ST_ROWS: begin
            sum_a_in    = sum_a_add;
            sum_b_in    = sum_b_add;
            position_in = position_inc;
            end_in      = byte_in;
            state_in    = ST_FLOATS;
            hit         = 1'b1;
         end
         ST_FLOATS: begin
            sum_a_in    = sum_a_add;
            sum_b_in    = sum_b_add;
            position_in = position_inc;
            end_in      = position_inc + {dump_product, 2'b00};
            state_in    = ST_PAYLOAD;
            hit         = 1'b1;
         end
         ST_PAYLOAD: begin
            sum_a_in    = sum_a_add;
            sum_b_in    = sum_b_add;
            position_in = position_inc;
            if (position_inc == end_ff) begin
               state_in = ST_CHECK1;
            end
            hit = 1'b1;
         end
         ST_CHECK1: begin
            if (byte_in == sum_a_ff) begin
               state_in = ST_CHECK2;
            end else begin
               state_in  = ST_SYNC1;
               error_in  = error_ff + 1'b1;
               hit       = 1'b1;
               kind      = KIND_ERROR;
               out_data  = 8'd0;
               out_index = 8'd0;
            end
         end
         ST_CHECK2: begin
            state_in  = ST_SYNC1;
            hit       = 1'b1;
            out_data  = 8'd0;
            out_index = 8'd0;
            if (byte_in == sum_b_ff) begin
               kind = KIND_GOOD;
            end else begin
               kind     = KIND_ERROR;
               error_in = error_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_SYNC1;
         end
      endcase
   end

   assign result_valid         = accept & hit;
   assign result.result_kind   = kind;
   assign result.data_byte     = out_data;
   assign result.byte_index    = out_index;
   assign result.frame_is_dump = dump_in;
   assign result.request_tag   = dump_in ? 32'd0 : request_in;
   assign result.frame_length  = end_in;
   assign result.error_total   = 16'(error_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RESET;
         sync_second_ff <= SYNC_SECOND_RESET;
         cmd_type_ff    <= CMD_TYPE_RESET;
         dump_type_ff   <= DUMP_TYPE_RESET;
         state_ff       <= ST_SYNC1;
         sum_a_ff       <= 8'd0;
         sum_b_ff       <= 8'd0;
         request_ff     <= 32'd0;
         end_ff         <= 8'd0;
         position_ff    <= 8'd0;
         error_ff       <= '0;
         dump_ff        <= 1'b0;
      end else begin
         sync_first_ff  <= sync_first_in;
         sync_second_ff <= sync_second_in;
         cmd_type_ff    <= cmd_type_in;
         dump_type_ff   <= dump_type_in;
         if (accept) begin
            state_ff    <= state_in;
            sum_a_ff    <= sum_a_in;
            sum_b_ff    <= sum_b_in;
            request_ff  <= request_in;
            end_ff      <= end_in;
            position_ff <= position_in;
            error_ff    <= error_in;
            dump_ff     <= dump_in;
         end
      end
   end

endmodule

// ===== rtl/sfcp_queue.sv =====
module sfcp_queue
   import sfcp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_en,
   input  result_type wr_data,
   output logic       full,
   input  logic       rd_en,
   output logic       empty,
   output result_type rd_data
);

   result_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_BITS-1:0] count_ff, count_in;
   logic                        do_write;
   logic                        do_read;

   assign full     = (count_ff == QUEUE_COUNT_BITS'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_write = wr_en & ~full;
   assign do_read  = rd_en & ~empty;
   assign rd_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_write) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_read) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_write & ~do_read) begin
         count_in = count_ff + 1'b1;
      end else if (do_read & ~do_write) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/sfcp_checker.sv =====
`include "sync_framed_command_parser_macros.svh"

module sfcp_checker
   import sfcp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        push,
   input logic        full,
   input logic        empty,
   input logic [1:0]  rsp_result_kind,
   input logic [7:0]  rsp_data_byte,
   input logic [7:0]  rsp_byte_index,
   input logic        rsp_frame_is_dump,
   input logic [31:0] rsp_request_tag
);

   `SFCP_ASSERT_NEXT(a_empty_after_reset, clock, reset, empty)
   `SFCP_ASSERT_NEXT(a_no_result_without_input, clock, (!reset && empty && !(push && !full)), empty)
   `SFCP_ASSERT_IMPLY(a_report_fields_zero, clock, reset, (!empty && rsp_result_kind != KIND_BYTE), (rsp_data_byte == 8'd0 && rsp_byte_index == 8'd0))
   `SFCP_ASSERT_IMPLY(a_dump_has_no_tag, clock, reset, (!empty && rsp_frame_is_dump), (rsp_request_tag == 32'd0))

endmodule

bind sync_framed_command_parser sfcp_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .push              (push),
   .full              (full),
   .empty             (empty),
   .rsp_result_kind   (rsp_result_kind),
   .rsp_data_byte     (rsp_data_byte),
   .rsp_byte_index    (rsp_byte_index),
   .rsp_frame_is_dump (rsp_frame_is_dump),
   .rsp_request_tag   (rsp_request_tag)
);

// ===== bench/tb_sync_framed_command_parser.sv =====
`timescale 1ns / 100ps

module tb_sync_framed_command_parser;
   import sfcp_pkg::*;

   localparam int FAULT_NONE = 0;
   localparam int FAULT_FIRST = 1;
   localparam int FAULT_SECOND = 2;
   localparam int FAULT_CUT = 3;
   localparam int RANDOM_FILL = -1;
   localparam int DRAIN_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_byte_in = 8'd0;
   logic        empty;
   logic        pop = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_data_byte;
   logic [7:0]  rsp_byte_index;
   logic        rsp_frame_is_dump;
   logic [31:0] rsp_request_tag;
   logic [7:0]  rsp_frame_length;
   logic [15:0] rsp_error_total;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = 8'd0;
   logic [7:0]  csr_wdata = 8'd0;

   logic [7:0] sync_first_value = SYNC_FIRST_RESET;
   logic [7:0] sync_second_value = SYNC_SECOND_RESET;
   logic [7:0] command_type_value = CMD_TYPE_RESET;
   logic [7:0] dump_type_value = DUMP_TYPE_RESET;

   parse_state_type             model_state = ST_SYNC1;
   logic [7:0]                  model_sum_a = 8'd0;
   logic [7:0]                  model_sum_b = 8'd0;
   logic [31:0]                 model_tag = 32'd0;
   logic [7:0]                  model_end = 8'd0;
   logic [7:0]                  model_position = 8'd0;
   logic [ERROR_COUNT_BITS-1:0] model_errors = '0;
   logic                        model_in_dump = 1'b0;

   result_type reports_due[$];
   int         mismatch_count = 0;
   int         bytes_fed = 0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;

   sync_framed_command_parser i_dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_byte_in(req_byte_in),
      .empty(empty),
      .pop(pop),
      .rsp_result_kind(rsp_result_kind),
      .rsp_data_byte(rsp_data_byte),
      .rsp_byte_index(rsp_byte_index),
      .rsp_frame_is_dump(rsp_frame_is_dump),
      .rsp_request_tag(rsp_request_tag),
      .rsp_frame_length(rsp_frame_length),
      .rsp_error_total(rsp_error_total),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic flag_mismatch(input string message);
      $display("MISMATCH: %s", message);
      mismatch_count++;
   endtask

   task automatic queue_report(input result_kind_type kind, input logic [7:0] data,
                               input logic [7:0] index);
      result_type r;
      r.result_kind = kind;
      r.data_byte = data;
      r.byte_index = index;
      r.frame_is_dump = model_in_dump;
      r.request_tag = model_in_dump ? 32'd0 : model_tag;
      r.frame_length = model_end;
      r.error_total = model_errors[15:0];
      reports_due.push_back(r);
   endtask

   task automatic parse_received_byte(input logic [7:0] b);
      logic [7:0]  index;
      logic [31:0] span;
      int          shift;
      case (model_state)
         ST_SYNC1: begin
            if (b == sync_first_value) model_state = ST_SYNC2;
         end
         ST_SYNC2: begin
            model_state = (b == sync_second_value) ? ST_TYPE : ST_SYNC1;
         end
         ST_TYPE: begin
            if (b == command_type_value) begin
               model_sum_a = 8'd0;
               model_sum_b = 8'd0;
               model_in_dump = 1'b0;
               model_state = ST_RQ1;
            end else if (b == dump_type_value) begin
               model_sum_a = 8'd0;
               model_sum_b = 8'd0;
               model_in_dump = 1'b1;
               model_position = 8'd1;
               model_state = ST_ROWS;
            end else begin
               model_state = ST_SYNC1;
            end
         end
         ST_RQ1, ST_RQ2, ST_RQ3, ST_RQ4: begin
            model_sum_a += b;
            model_sum_b += model_sum_a;
            shift = 8 * (int'(model_state) - int'(ST_RQ1));
            model_tag[shift +: 8] = b;
            model_state = parse_state_type'(model_state + 4'd1);
         end
         ST_LEN: begin
            model_sum_a += b;
            model_sum_b += model_sum_a;
            model_end = b;
            model_position = 8'd0;
            model_state = ST_PAYLOAD;
         end
         ST_ROWS: begin
            model_sum_a += b;
            model_sum_b += model_sum_a;
            index = model_position;
            model_position++;
            model_end = b;
            model_state = ST_FLOATS;
            queue_report(KIND_BYTE, b, index);
         end
         ST_FLOATS: begin
            model_sum_a += b;
            model_sum_b += model_sum_a;
            index = model_position;
            model_position++;
            span = model_end * b * 4;
            model_end = model_position + span[7:0];
            model_state = ST_PAYLOAD;
            queue_report(KIND_BYTE, b, index);
         end
         ST_PAYLOAD: begin
            model_sum_a += b;
            model_sum_b += model_sum_a;
            index = model_position;
            model_position++;
            if (model_position == model_end) model_state = ST_CHECK1;
            queue_report(KIND_BYTE, b, index);
         end
         ST_CHECK1: begin
            if (b == model_sum_a) begin
               model_state = ST_CHECK2;
            end else begin
               model_state = ST_SYNC1;
               model_errors++;
               queue_report(KIND_ERROR, 8'd0, 8'd0);
            end
         end
         ST_CHECK2: begin
            model_state = ST_SYNC1;
            if (b == model_sum_b) begin
               queue_report(KIND_GOOD, 8'd0, 8'd0);
            end else begin
               model_errors++;
               queue_report(KIND_ERROR, 8'd0, 8'd0);
            end
         end
         default: begin
            model_state = ST_SYNC1;
         end
      endcase
   endtask

   task automatic feed_byte(input logic [7:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_byte_in <= value;
      do @(posedge clock); while (full !== 1'b0);
      bytes_fed++;
      parse_received_byte(value);
   endtask

   task automatic check_report();
      result_type want;
      if (reports_due.size() == 0) begin
         flag_mismatch($sformatf("unexpected result: kind %0d data %0h index %0d",
                                 rsp_result_kind, rsp_data_byte, rsp_byte_index));
         return;
      end
      want = reports_due.pop_front();
      if (rsp_result_kind !== want.result_kind)
         flag_mismatch($sformatf("result_kind: got %0d, expected %0d",
                                 rsp_result_kind, want.result_kind));
      if (rsp_data_byte !== want.data_byte)
         flag_mismatch($sformatf("data_byte: got %0h, expected %0h",
                                 rsp_data_byte, want.data_byte));
      if (rsp_byte_index !== want.byte_index)
         flag_mismatch($sformatf("byte_index: got %0d, expected %0d",
                                 rsp_byte_index, want.byte_index));
      if (rsp_frame_is_dump !== want.frame_is_dump)
         flag_mismatch($sformatf("frame_is_dump: got %0d, expected %0d",
                                 rsp_frame_is_dump, want.frame_is_dump));
      if (rsp_request_tag !== want.request_tag)
         flag_mismatch($sformatf("request_tag: got %0h, expected %0h",
                                 rsp_request_tag, want.request_tag));
      if (rsp_frame_length !== want.frame_length)
         flag_mismatch($sformatf("frame_length: got %0d, expected %0d",
                                 rsp_frame_length, want.frame_length));
      if (rsp_error_total !== want.error_total)
         flag_mismatch($sformatf("error_total: got %0d, expected %0d",
                                 rsp_error_total, want.error_total));
   endtask

   always @(posedge clock) begin
      if (!reset && pop && empty === 1'b0) check_report();
      pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic await_all_reports();
      int         waited;
      result_type lost;
      waited = 0;
      push <= 1'b0;
      while (reports_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      while (reports_due.size() != 0) begin
         lost = reports_due.pop_front();
         flag_mismatch($sformatf("missing result: kind %0d index %0d",
                                 lost.result_kind, lost.byte_index));
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [7:0] index, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (index)
         CSR_SYNC_FIRST: sync_first_value = value;
         CSR_SYNC_SECOND: sync_second_value = value;
         CSR_CMD_TYPE: command_type_value = value;
         CSR_DUMP_TYPE: dump_type_value = value;
         default: ;
      endcase
   endtask

   task automatic program_parser(input logic [7:0] first, input logic [7:0] second,
                                 input logic [7:0] command, input logic [7:0] dump);
      await_all_reports();
      write_register(8'($urandom_range(255, 4)), 8'($urandom));
      write_register(CSR_SYNC_FIRST, first);
      write_register(CSR_SYNC_SECOND, second);
      write_register(CSR_CMD_TYPE, command);
      write_register(CSR_DUMP_TYPE, dump);
      csr_valid <= 1'b0;
   endtask

   // A dump frame is sized by rows and floats, a command frame by its length byte.
   task automatic send_frame(input bit as_dump, input logic [31:0] tag,
                             input logic [7:0] size_a, input logic [7:0] size_b,
                             input int fill, input int fault);
      logic [7:0]  body[$];
      logic [7:0]  frame[$];
      logic [7:0]  run_a;
      logic [7:0]  run_b;
      logic [7:0]  end_pos;
      logic [31:0] span;
      int          payload_count;
      int          keep;
      int          k;
      run_a = 8'd0;
      run_b = 8'd0;
      frame.push_back(sync_first_value);
      frame.push_back(sync_second_value);
      if (as_dump) begin
         frame.push_back(dump_type_value);
         body.push_back(size_a);
         body.push_back(size_b);
         span = 3 + size_a * size_b * 4;
         end_pos = span[7:0];
         payload_count = (end_pos - 3) & 255;
      end else begin
         frame.push_back(command_type_value);
         for (k = 0; k < 4; k++) body.push_back(tag[8*k +: 8]);
         body.push_back(size_a);
         payload_count = size_a;
      end
      if (payload_count == 0) payload_count = 256;
      repeat (payload_count) body.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
      foreach (body[i]) begin
         run_a += body[i];
         run_b += run_a;
         frame.push_back(body[i]);
      end
      if (fault == FAULT_FIRST) begin
         run_a ^= 8'($urandom_range(255, 1));
         if (run_b == sync_first_value) run_b = ~run_b;
      end
      if (fault == FAULT_SECOND) run_b ^= 8'($urandom_range(255, 1));
      frame.push_back(run_a);
      frame.push_back(run_b);
      if (fault == FAULT_CUT) begin
         keep = $urandom_range(frame.size() - 1, 1);
         while (frame.size() > keep) void'(frame.pop_back());
      end
      foreach (frame[i]) feed_byte(frame[i]);
   endtask

   task automatic test_default_frames();
      send_frame(1'b0, 32'h0000_0000, 8'd1, 8'd0, 8'h00, FAULT_NONE);
      send_frame(1'b0, 32'hFFFF_FFFF, 8'd20, 8'd0, 8'hFF, FAULT_NONE);
      send_frame(1'b1, 32'd0, 8'd1, 8'd1, RANDOM_FILL, FAULT_NONE);
      send_frame(1'b1, 32'd0, 8'd255, 8'd255, RANDOM_FILL, FAULT_NONE);
      send_frame(1'b0, $urandom, 8'd3, 8'd0, RANDOM_FILL, FAULT_NONE);
   endtask

   task automatic test_wrapped_lengths();
      send_frame(1'b0, $urandom, 8'd0, 8'd0, RANDOM_FILL, FAULT_NONE);
      send_frame(1'b1, 32'd0, 8'd65, 8'd1, RANDOM_FILL, FAULT_NONE);
   endtask

   task automatic test_sync_hunt();
      feed_byte(sync_first_value);
      feed_byte(sync_first_value);
      feed_byte(sync_second_value);
      feed_byte(command_type_value);
      send_frame(1'b0, $urandom, 8'd2, 8'd0, RANDOM_FILL, FAULT_NONE);
      feed_byte(sync_first_value);
      feed_byte(8'd200);
      send_frame(1'b1, 32'd0, 8'd1, 8'd2, RANDOM_FILL, FAULT_NONE);
      feed_byte(sync_first_value);
      feed_byte(sync_second_value);
      feed_byte(8'h00);
      send_frame(1'b0, $urandom, 8'd1, 8'd0, RANDOM_FILL, FAULT_NONE);
   endtask

   task automatic test_check_bytes();
      send_frame(1'b0, $urandom, 8'd4, 8'd0, RANDOM_FILL, FAULT_FIRST);
      send_frame(1'b0, $urandom, 8'd4, 8'd0, RANDOM_FILL, FAULT_SECOND);
      send_frame(1'b1, 32'd0, 8'd2, 8'd1, RANDOM_FILL, FAULT_FIRST);
      send_frame(1'b1, 32'd0, 8'd1, 8'd2, RANDOM_FILL, FAULT_SECOND);
      send_frame(1'b0, $urandom, 8'd1, 8'd0, RANDOM_FILL, FAULT_NONE);
   endtask

   task automatic test_register_settings();
      program_parser(8'd0, 8'd0, 8'd0, 8'd0);
      send_frame(1'b0, $urandom, 8'd3, 8'd0, RANDOM_FILL, FAULT_NONE);
      program_parser(8'd255, 8'd255, 8'd255, 8'd255);
      send_frame(1'b0, $urandom, 8'd2, 8'd0, 8'hFF, FAULT_NONE);
      program_parser(8'd255, 8'd0, 8'd0, 8'd255);
      send_frame(1'b0, $urandom, 8'd2, 8'd0, RANDOM_FILL, FAULT_NONE);
      send_frame(1'b1, 32'd0, 8'd1, 8'd1, RANDOM_FILL, FAULT_SECOND);
      program_parser(8'd0, 8'd255, 8'd255, 8'd0);
      send_frame(1'b1, 32'd0, 8'd2, 8'd2, RANDOM_FILL, FAULT_NONE);
      send_frame(1'b0, $urandom, 8'd5, 8'd0, RANDOM_FILL, FAULT_FIRST);
      program_parser(SYNC_FIRST_RESET, SYNC_SECOND_RESET, CMD_TYPE_RESET, DUMP_TYPE_RESET);
   endtask

   // Several failing frames in a row, then a good one that carries the count.
   task automatic test_error_count();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_parser(SYNC_FIRST_RESET, SYNC_SECOND_RESET, CMD_TYPE_RESET, DUMP_TYPE_RESET);
      repeat (4) send_frame(1'b0, $urandom, 8'd1, 8'd0, RANDOM_FILL, FAULT_FIRST);
      send_frame(1'b0, $urandom, 8'd1, 8'd0, RANDOM_FILL, FAULT_SECOND);
      send_frame(1'b0, $urandom, 8'd1, 8'd0, RANDOM_FILL, FAULT_NONE);
      await_all_reports();
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                      input int byte_count);
      logic [7:0] command;
      logic [7:0] dump;
      logic [7:0] size_a;
      logic [7:0] size_b;
      int         start;
      int         pick;
      int         fault;
      bit         as_dump;
      command = 8'($urandom);
      dump = 8'($urandom);
      if (dump == command) dump = command ^ 8'h01;
      program_parser(8'($urandom), 8'($urandom), command, dump);
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      start = bytes_fed;
      while (bytes_fed - start < byte_count) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            pick = $urandom_range(99);
            fault = (pick < 75) ? FAULT_NONE : (pick < 85) ? FAULT_FIRST :
                    (pick < 95) ? FAULT_SECOND : FAULT_CUT;
            as_dump = $urandom_range(1);
            if ($urandom_range(19) == 0) begin
               size_a = 8'($urandom);
               size_b = 8'($urandom);
            end else if (as_dump) begin
               size_a = 8'($urandom_range(3, 1));
               size_b = 8'($urandom_range(2, 1));
            end else begin
               size_a = 8'($urandom_range(12, 1));
               size_b = 8'd0;
            end
            send_frame(as_dump, $urandom, size_a, size_b, RANDOM_FILL, fault);
         end else if (pick < 95) begin
            repeat ($urandom_range(6, 1)) begin
               pick = $urandom_range(2);
               feed_byte(pick == 0 ? sync_first_value :
                         pick == 1 ? sync_second_value : 8'($urandom));
            end
         end else begin
            await_all_reports();
         end
      end
      await_all_reports();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 6;
      recv_idle_pct = 81;
      test_default_frames();
      test_wrapped_lengths();
      test_sync_hunt();
      test_check_bytes();
      test_register_settings();
      test_random_traffic(6, 81, 50);
      test_random_traffic(81, 6, 50);
      test_random_traffic(0, 0, 50);
      test_error_count();
      await_all_reports();
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
